// ===== rtl/gmz_pkg.sv =====
// ----------------------------------------------------------------------------
// gmz_pkg
// Shared types and constants for the grid maze depth-first path search block.
// ----------------------------------------------------------------------------
package gmz_pkg;

    localparam int DIM_W   = 7;
    localparam int COORD_W = 6;
    localparam int IDX_W   = 12;
    localparam int LEN_W   = 13;
    localparam int ACT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef logic [2:0] t_dir;

    localparam t_dir DIR_N   = 3'd0;
    localparam t_dir DIR_E   = 3'd1;
    localparam t_dir DIR_S   = 3'd2;
    localparam t_dir DIR_W   = 3'd3;
    localparam t_dir DIR_END = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_CLEAR,
        S_EXIT_CHK,
        S_STEP,
        S_PROBE,
        S_POP_WAIT,
        S_EMIT
    } t_state;

endpackage

// ===== rtl/gmz_if.sv =====
// ----------------------------------------------------------------------------
// gmz interfaces
// Handshake channels of the maze search block: configuration, item, result.
// ----------------------------------------------------------------------------
interface gmz_cfg_if;
    import gmz_pkg::*;

    logic             valid;
    logic             ready;
    logic             index;
    logic [DIM_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface gmz_in_if;
    import gmz_pkg::*;

    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic               is_wall;
    logic [IDX_W-1:0]   path_index;

    modport source (output valid, output action, output cell_row, output cell_col,
                    output is_wall, output path_index, input ready);
    modport sink   (input valid, input action, input cell_row, input cell_col,
                    input is_wall, input path_index, output ready);
endinterface

interface gmz_out_if;
    import gmz_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [LEN_W-1:0]   path_length;
    logic [COORD_W-1:0] step_row;
    logic [COORD_W-1:0] step_col;

    modport source (output valid, output found, output path_length, output step_row,
                    output step_col, input ready);
    modport sink   (input valid, input found, input path_length, input step_row,
                    input step_col, output ready);
endinterface

// ===== rtl/gmz_ram.sv =====
// ----------------------------------------------------------------------------
// gmz_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gmz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/grid_maze_dfs_path_search.sv =====
// ----------------------------------------------------------------------------
// grid_maze_dfs_path_search
// Depth-first maze solver over a wall grid held in block RAM.
// ----------------------------------------------------------------------------
// One item at a time. A path read of an entry on the found path goes through
// S_RD_WAIT (stack RAM read) and S_EMIT; a cell write, any other read and an
// unused action go straight to S_EMIT. A search first sweeps the visited RAM,
// one entry a cycle, 4**ceil(log2(MAX_DIM)) entries (4096 at MAX_DIM = 64),
// then walks the grid: a probe inside the grid reads the wall and visited RAMs
// in S_STEP and decides in S_PROBE, one that leaves the grid is skipped in
// S_STEP; a backtrack reads the stack RAM in S_STEP and pops in S_POP_WAIT.
// The result is held in an output register, so the block returns to idle as
// soon as the previous result has been taken. Configuration writes are taken
// in any cycle and must only happen while the block is idle.
module grid_maze_dfs_path_search #(
    parameter int MAX_DIM = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gmz_cfg_if.sink        i_cfg,
    gmz_in_if.sink         i_in,
    gmz_out_if.source      o_out
);
    import gmz_pkg::*;

    localparam int CW    = $clog2(MAX_DIM);
    localparam int AW    = 2 * CW;
    localparam int CELLS = 1 << AW;
    localparam int DW    = AW + 1;
    localparam int SW    = 2 * CW + 2;
    localparam int CMPW  = (DW > IDX_W) ? DW : IDX_W;

    t_state r_state, n_state;

    logic [DIM_W-1:0]   r_cfg_rows, r_cfg_cols;
    logic [CW-1:0]      r_row, n_row, r_col, n_col;
    logic [CW-1:0]      r_nrow, n_nrow, r_ncol, n_ncol;
    logic [CW-1:0]      r_er, n_er, r_ec, n_ec;
    t_dir               r_dir, n_dir;
    logic [DW-1:0]      r_depth, n_depth;
    logic               r_found, n_found;
    logic [AW-1:0]      r_clr, n_clr;
    logic [COORD_W-1:0] r_srow, n_srow, r_scol, n_scol;

    logic               r_out_valid;
    logic               r_out_found;
    logic [LEN_W-1:0]   r_out_len;
    logic [COORD_W-1:0] r_out_row, r_out_col;

    logic               wall_we, wall_wdata, wall_rdata;
    logic [AW-1:0]      wall_waddr, wall_raddr;
    logic               vis_we, vis_wdata, vis_rdata;
    logic [AW-1:0]      vis_waddr, vis_raddr;
    logic               stk_we;
    logic [AW-1:0]      stk_waddr, stk_raddr;
    logic [SW-1:0]      stk_wdata, stk_rdata;

    logic               in_fire, out_slot_free, emit;
    logic [CW-1:0]      cfg_er, cfg_ec;
    logic [CW-1:0]      step_nrow, step_ncol;
    logic               step_blocked, at_exit;

    assign in_fire       = i_in.valid && i_in.ready;
    assign out_slot_free = !r_out_valid || o_out.ready;
    assign emit          = (r_state == S_EMIT) && out_slot_free;
    assign at_exit       = (r_row == r_er) && (r_col == r_ec);

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);

    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_out_found;
    assign o_out.path_length = r_out_len;
    assign o_out.step_row    = r_out_row;
    assign o_out.step_col    = r_out_col;

    // last row and column in use, clamped to 0..MAX_DIM-1
    always_comb begin
        if (r_cfg_rows == '0) begin
            cfg_er = '0;
        end else if (32'(r_cfg_rows) > MAX_DIM) begin
            cfg_er = CW'(MAX_DIM - 1);
        end else begin
            cfg_er = CW'(r_cfg_rows - 7'd1);
        end
        if (r_cfg_cols == '0) begin
            cfg_ec = '0;
        end else if (32'(r_cfg_cols) > MAX_DIM) begin
            cfg_ec = CW'(MAX_DIM - 1);
        end else begin
            cfg_ec = CW'(r_cfg_cols - 7'd1);
        end
    end

    // neighbor in the current direction
    always_comb begin
        step_nrow    = r_row;
        step_ncol    = r_col;
        step_blocked = 1'b1;
        case (r_dir)
            DIR_N: begin
                step_blocked = (r_row == '0);
                step_nrow    = r_row - CW'(1);
            end
            DIR_E: begin
                step_blocked = (r_col == r_ec);
                step_ncol    = r_col + CW'(1);
            end
            DIR_S: begin
                step_blocked = (r_row == r_er);
                step_nrow    = r_row + CW'(1);
            end
            DIR_W: begin
                step_blocked = (r_col == '0);
                step_ncol    = r_col - CW'(1);
            end
            default: begin
                step_blocked = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows <= DIM_RESET;
            r_cfg_cols <= DIM_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_GRID_ROWS: r_cfg_rows <= i_cfg.data;
                REG_GRID_COLS: r_cfg_cols <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in.action)
                        ACT_SEARCH: n_state = S_CLEAR;
                        ACT_READ: begin
                            if (r_found && (CMPW'(i_in.path_index) < CMPW'(r_depth))) begin
                                n_state = S_RD_WAIT;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            S_RD_WAIT: n_state = S_EMIT;
            S_CLEAR: begin
                if (r_clr == AW'(CELLS - 1)) begin
                    n_state = S_EXIT_CHK;
                end
            end
            S_EXIT_CHK: n_state = wall_rdata ? S_EMIT : S_STEP;
            S_STEP: begin
                if (r_dir == DIR_END) begin
                    n_state = (r_depth == '0) ? S_EMIT : S_POP_WAIT;
                end else if (at_exit) begin
                    n_state = S_EMIT;
                end else if (!step_blocked) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE:    n_state = S_STEP;
            S_POP_WAIT: n_state = S_STEP;
            S_EMIT: begin
                if (out_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_nrow  = r_nrow;
        n_ncol  = r_ncol;
        n_er    = r_er;
        n_ec    = r_ec;
        n_dir   = r_dir;
        n_depth = r_depth;
        n_found = r_found;
        n_clr   = r_clr;
        n_srow  = r_srow;
        n_scol  = r_scol;

        wall_we    = 1'b0;
        wall_waddr = {CW'(i_in.cell_row), CW'(i_in.cell_col)};
        wall_wdata = i_in.is_wall;
        wall_raddr = {r_er, r_ec};
        vis_we     = 1'b0;
        vis_waddr  = r_clr;
        vis_wdata  = 1'b0;
        vis_raddr  = {step_nrow, step_ncol};
        stk_we     = 1'b0;
        stk_waddr  = r_depth[AW-1:0];
        stk_wdata  = {r_row, r_col, r_dir[1:0]};
        stk_raddr  = AW'(i_in.path_index);

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_srow = '0;
                    n_scol = '0;
                    case (i_in.action)
                        ACT_WRITE: begin
                            wall_we = (32'(i_in.cell_row) < MAX_DIM) &&
                                      (32'(i_in.cell_col) < MAX_DIM);
                        end
                        ACT_SEARCH: begin
                            n_depth = '0;
                            n_found = 1'b0;
                            n_clr   = '0;
                            n_er    = cfg_er;
                            n_ec    = cfg_ec;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_WAIT: begin
                n_srow = COORD_W'(stk_rdata[SW-1 -: CW]);
                n_scol = COORD_W'(stk_rdata[CW+1 -: CW]);
            end
            S_CLEAR: begin
                vis_we = 1'b1;
                n_clr  = r_clr + AW'(1);
            end
            S_EXIT_CHK: begin
                if (!wall_rdata) begin
                    vis_we    = 1'b1;
                    vis_waddr = '0;
                    vis_wdata = 1'b1;
                    n_row     = '0;
                    n_col     = '0;
                    n_dir     = DIR_E;
                end
            end
            S_STEP: begin
                wall_raddr = {step_nrow, step_ncol};
                if (r_dir == DIR_END) begin
                    if (r_depth != '0) begin
                        n_depth   = r_depth - DW'(1);
                        stk_raddr = n_depth[AW-1:0];
                    end
                end else if (at_exit) begin
                    stk_we  = 1'b1;
                    n_depth = r_depth + DW'(1);
                    n_found = 1'b1;
                end else if (step_blocked) begin
                    n_dir = r_dir + 3'd1;
                end else begin
                    n_nrow = step_nrow;
                    n_ncol = step_ncol;
                end
            end
            S_PROBE: begin
                if (!wall_rdata && !vis_rdata) begin
                    vis_we    = 1'b1;
                    vis_waddr = {r_nrow, r_ncol};
                    vis_wdata = 1'b1;
                    stk_we    = 1'b1;
                    n_depth   = r_depth + DW'(1);
                    n_row     = r_nrow;
                    n_col     = r_ncol;
                    n_dir     = DIR_N;
                end else begin
                    n_dir = r_dir + 3'd1;
                end
            end
            S_POP_WAIT: begin
                n_row = stk_rdata[SW-1 -: CW];
                n_col = stk_rdata[CW+1 -: CW];
                n_dir = {1'b0, stk_rdata[1:0]};
            end
            S_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_found <= n_found;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_col  <= n_col;
        r_nrow <= n_nrow;
        r_ncol <= n_ncol;
        r_er   <= n_er;
        r_ec   <= n_ec;
        r_dir  <= n_dir;
        r_clr  <= n_clr;
        r_srow <= n_srow;
        r_scol <= n_scol;
        if (emit) begin
            r_out_found <= r_found;
            r_out_len   <= r_found ? LEN_W'(r_depth) : '0;
            r_out_row   <= r_srow;
            r_out_col   <= r_scol;
        end
    end

    gmz_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_wall_ram (
        .i_clk   (i_clk),
        .i_we    (wall_we),
        .i_waddr (wall_waddr),
        .i_wdata (wall_wdata),
        .i_raddr (wall_raddr),
        .o_rdata (wall_rdata)
    );

    gmz_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_visited_ram (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_raddr (vis_raddr),
        .o_rdata (vis_rdata)
    );

    gmz_ram #(
        .WIDTH (SW),
        .DEPTH (CELLS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

`ifndef SYNTH
    a_found_has_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_found) |-> (r_depth != '0))
        else $error("found search with empty trail");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_depth) <= CELLS))
        else $error("trail depth beyond storage");

    a_probe_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_nrow <= r_er && r_ncol <= r_ec))
        else $error("probe outside the grid");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("transaction accepted without leaving idle");
`endif

endmodule
